FILE: src/bpa_pkg.sv
package bpa_pkg;

   localparam int NUM_BLOCKS  = 1024;
   localparam int BLOCK_BYTES = 4096;
   localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);

   localparam int MAP_BITS  = 32;
   localparam int BIT_W     = $clog2(MAP_BITS);
   localparam int MAP_WORDS = (NUM_BLOCKS + MAP_BITS - 1) / MAP_BITS;
   localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int IDX_W     = WORD_W + BIT_W;

   localparam int ADDR_W    = 32;
   localparam int LEN_W     = 32;
   localparam int IDX_FULL_W = ADDR_W - BLOCK_SHIFT;
   localparam int BADDR_W   = 22;
   localparam int COUNT_W   = 11;
   localparam int COUNT_MAX = (1 << COUNT_W) - 1;

   // Cap on the effective block count and on the used counter
   localparam int COUNT_CAP = (NUM_BLOCKS > COUNT_MAX) ? COUNT_MAX : NUM_BLOCKS;
   localparam int COUNT_RESET = 1024;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic [CSR_AW-1:0] CSR_BLOCK_COUNT = 3'd0;

   typedef enum logic [1:0] {
      ACT_ALLOC        = 2'd0,
      ACT_FREE         = 2'd1,
      ACT_REGION_ALLOC = 2'd2,
      ACT_REGION_FREE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_NO_FREE = 2'd1,
      STAT_RANGE   = 2'd2
   } status_type;

   typedef struct packed {
      action_type          action;
      logic [ADDR_W-1:0]   address;
      logic [LEN_W-1:0]    length;
   } req_type;

   typedef struct packed {
      logic [BADDR_W-1:0]  block_address;
      status_type          status;
      logic [COUNT_W-1:0]  used_count;
   } rsp_type;

   typedef struct packed {
      logic                wr_en;
      logic [WORD_W-1:0]   addr;
      logic [MAP_BITS-1:0] data;
   } map_wr_type;

endpackage

FILE: src/bpa_map_store.sv
module bpa_map_store (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [bpa_pkg::WORD_W-1:0]   rd_addr,
   input  bpa_pkg::map_wr_type          wr,
   output logic [bpa_pkg::MAP_BITS-1:0] rd_data
);

   logic [bpa_pkg::MAP_BITS-1:0]  map_mem [bpa_pkg::MAP_WORDS];
   logic [bpa_pkg::MAP_WORDS-1:0] valid_ff;
   logic [bpa_pkg::MAP_WORDS-1:0] valid_in;
   logic [bpa_pkg::MAP_BITS-1:0]  rd_data_ff;
   logic                          rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         map_mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr.wr_en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   // An entry never written reads as all free
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '1;

endmodule

FILE: src/bitmap_page_allocator.sv
// First-fit bitmap page allocator for 1024 pages of 4 KiB, one bit per page
// (1 = free). Each request transaction carries an action (allocate one, free
// one, allocate region, free region), a byte address and a byte length, and
// produces exactly one response transaction with the allocated page address,
// a status (ok, no free page, out of range) and the used-page count after the
// action. Each accepted request visits W of the 32-bit bitmap words before its
// response is offered: up to 32 for an allocation (the scan stops at the first
// word holding a free page), the words spanned by a region, one for a single
// free, none for a request that touches nothing. The block is ready again in
// the cycle in which the response is first offered; a finished request holds
// while an earlier response still waits to be taken. The bitmap memory
// delivers one word per cycle through a single registered read port; reads
// are issued one word ahead so the read-modify-write loop keeps that pace.
// One request is in flight at a time; a finished response waits in an output
// register while the next request is accepted. The bitmap needs no clearing
// pass after reset: per-word valid bits make unwritten words read as free.
// Register block_count (byte address 0) limits the pages searched and touched;
// write it only while the block is idle.
module bitmap_page_allocator (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  bpa_pkg::req_type           req_item,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output bpa_pkg::rsp_type           rsp_item,

   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [bpa_pkg::CSR_AW-1:0] paddr,
   input  logic [bpa_pkg::CSR_DW-1:0] pwdata,
   output logic [bpa_pkg::CSR_DW-1:0] prdata,
   output logic                       pready
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   localparam logic [bpa_pkg::COUNT_W-1:0] CAP = bpa_pkg::COUNT_W'(bpa_pkg::COUNT_CAP);
   localparam logic [bpa_pkg::BIT_W-1:0]   TOP_BIT = bpa_pkg::BIT_W'(bpa_pkg::MAP_BITS - 1);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type                         state_ff, state_in;
   logic [bpa_pkg::COUNT_W-1:0]       block_count_ff, block_count_in;
   logic [bpa_pkg::COUNT_W-1:0]       used_total_ff, used_total_in;
   bpa_pkg::action_type               action_ff, action_in;
   logic [bpa_pkg::IDX_W-1:0]         start_ff, start_in;      // first page touched
   logic [bpa_pkg::IDX_W-1:0]         last_ff, last_in;        // last page touched
   logic [bpa_pkg::WORD_W-1:0]        word_ff, word_in;        // word whose data is here
   logic [bpa_pkg::COUNT_W-1:0]       delta_ff, delta_in;      // pages to count
   bpa_pkg::status_type               status_ff, status_in;
   logic [bpa_pkg::BADDR_W-1:0]       baddr_ff, baddr_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   bpa_pkg::rsp_type                  rsp_item_ff, rsp_item_in;

   // ---------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------
   logic csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr == bpa_pkg::CSR_BLOCK_COUNT);
   assign prdata    = (paddr == bpa_pkg::CSR_BLOCK_COUNT) ?
                      bpa_pkg::CSR_DW'(block_count_ff) : '0;

   always_comb begin
      block_count_in = block_count_ff;
      if (csr_write) begin
         block_count_in = pwdata[bpa_pkg::COUNT_W-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Request decode, done in the accept cycle
   // ---------------------------------------------------------------------
   logic [bpa_pkg::COUNT_W-1:0]    count_eff;
   logic [bpa_pkg::IDX_FULL_W-1:0] idx_full;
   logic [bpa_pkg::IDX_FULL_W-1:0] len_blocks;
   logic [bpa_pkg::IDX_FULL_W:0]   end_raw;
   logic [bpa_pkg::IDX_FULL_W:0]   count_wide;
   logic [bpa_pkg::COUNT_W-1:0]    end_clip;
   logic                           acc_touch;
   logic [bpa_pkg::IDX_W-1:0]      acc_start;
   logic [bpa_pkg::IDX_W-1:0]      acc_last;
   logic [bpa_pkg::COUNT_W-1:0]    acc_delta;
   bpa_pkg::status_type            acc_status;
   logic                           req_take;

   assign count_eff  = (block_count_ff > CAP) ? CAP : block_count_ff;
   assign idx_full   = req_item.address[bpa_pkg::ADDR_W-1:bpa_pkg::BLOCK_SHIFT];
   assign len_blocks = req_item.length[bpa_pkg::LEN_W-1:bpa_pkg::BLOCK_SHIFT];
   assign count_wide = (bpa_pkg::IDX_FULL_W + 1)'(count_eff);
   assign end_raw    = (bpa_pkg::IDX_FULL_W + 1)'(idx_full) +
                       (bpa_pkg::IDX_FULL_W + 1)'(len_blocks) +
                       (bpa_pkg::IDX_FULL_W + 1)'(1);
   assign end_clip   = (end_raw > count_wide) ? count_eff : bpa_pkg::COUNT_W'(end_raw);
   assign req_take   = req_valid && req_ready;

   always_comb begin
      acc_touch  = 1'b0;
      acc_start  = '0;
      acc_last   = '0;
      acc_delta  = '0;
      acc_status = bpa_pkg::STAT_OK;
      unique case (req_item.action)
         bpa_pkg::ACT_ALLOC: begin
            // Search the whole managed range; delta set on a hit
            acc_last = bpa_pkg::IDX_W'(count_eff - bpa_pkg::COUNT_W'(1));
            if (count_eff != '0) begin
               acc_touch = 1'b1;
            end else begin
               acc_status = bpa_pkg::STAT_NO_FREE;
            end
         end
         bpa_pkg::ACT_FREE: begin
            acc_start = bpa_pkg::IDX_W'(idx_full);
            acc_last  = bpa_pkg::IDX_W'(idx_full);
            if (req_item.address != '0) begin
               if ((bpa_pkg::IDX_FULL_W + 1)'(idx_full) < count_wide) begin
                  acc_touch = 1'b1;
                  acc_delta = bpa_pkg::COUNT_W'(1);
               end else begin
                  acc_status = bpa_pkg::STAT_RANGE;
               end
            end
         end
         bpa_pkg::ACT_REGION_ALLOC, bpa_pkg::ACT_REGION_FREE: begin
            acc_start = bpa_pkg::IDX_W'(idx_full);
            acc_last  = bpa_pkg::IDX_W'(end_clip - bpa_pkg::COUNT_W'(1));
            if (end_raw > count_wide) begin
               acc_status = bpa_pkg::STAT_RANGE;
            end
            if ((bpa_pkg::IDX_FULL_W + 1)'(idx_full) <
                (bpa_pkg::IDX_FULL_W + 1)'(end_clip)) begin
               acc_touch = 1'b1;
               acc_delta = end_clip - bpa_pkg::COUNT_W'(idx_full);
            end
         end
         default: begin
            acc_touch = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Bitmap memory: read one word ahead, modify, write back
   // ---------------------------------------------------------------------
   logic [bpa_pkg::WORD_W-1:0]   rd_addr;
   logic [bpa_pkg::MAP_BITS-1:0] word_data;
   bpa_pkg::map_wr_type          map_wr;

   assign rd_addr = (state_ff == ST_IDLE) ?
                    acc_start[bpa_pkg::IDX_W-1:bpa_pkg::BIT_W] :
                    word_ff + bpa_pkg::WORD_W'(1);

   bpa_map_store u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .wr      (map_wr),
      .rd_data (word_data)
   );

   // Mask of the pages in the current word that the request covers
   logic [bpa_pkg::BIT_W-1:0]    lo_bit;
   logic [bpa_pkg::BIT_W-1:0]    hi_bit;
   logic [bpa_pkg::MAP_BITS-1:0] range_mask;
   logic [bpa_pkg::MAP_BITS-1:0] hit;
   logic [bpa_pkg::MAP_BITS-1:0] first_hit;
   logic [bpa_pkg::BIT_W-1:0]    hit_pos;
   logic                         found;
   logic                         last_word;
   logic                         scan_done;

   assign last_word = (word_ff == last_ff[bpa_pkg::IDX_W-1:bpa_pkg::BIT_W]);
   assign lo_bit    = (word_ff == start_ff[bpa_pkg::IDX_W-1:bpa_pkg::BIT_W]) ?
                      start_ff[bpa_pkg::BIT_W-1:0] : '0;
   assign hi_bit    = last_word ? last_ff[bpa_pkg::BIT_W-1:0] : TOP_BIT;
   assign range_mask = ({bpa_pkg::MAP_BITS{1'b1}} << lo_bit) &
                       ({bpa_pkg::MAP_BITS{1'b1}} >> (TOP_BIT - hi_bit));

   // Isolate the lowest free page, then encode its position
   assign hit       = word_data & range_mask;
   assign first_hit = hit & (~hit + bpa_pkg::MAP_BITS'(1));
   assign found     = |hit;

   always_comb begin
      hit_pos = '0;
      for (int b = 0; b < bpa_pkg::MAP_BITS; b++) begin
         if (first_hit[b]) begin
            hit_pos = hit_pos | bpa_pkg::BIT_W'(b);
         end
      end
   end

   always_comb begin
      map_wr.wr_en = 1'b0;
      map_wr.addr  = word_ff;
      map_wr.data  = word_data;
      if (state_ff == ST_SCAN) begin
         unique case (action_ff)
            bpa_pkg::ACT_ALLOC: begin
               map_wr.wr_en = found;
               map_wr.data  = word_data & ~first_hit;
            end
            bpa_pkg::ACT_FREE, bpa_pkg::ACT_REGION_FREE: begin
               map_wr.wr_en = 1'b1;
               map_wr.data  = word_data | range_mask;
            end
            bpa_pkg::ACT_REGION_ALLOC: begin
               map_wr.wr_en = 1'b1;
               map_wr.data  = word_data & ~range_mask;
            end
            default: begin
               map_wr.wr_en = 1'b0;
            end
         endcase
      end
   end

   assign scan_done = last_word || ((action_ff == bpa_pkg::ACT_ALLOC) && found);

   // ---------------------------------------------------------------------
   // Used counter, saturating at zero and at the cap
   // ---------------------------------------------------------------------
   logic                        count_up;
   logic [bpa_pkg::COUNT_W:0]   used_sum;
   logic [bpa_pkg::COUNT_W-1:0] used_next;

   assign count_up = (action_ff == bpa_pkg::ACT_ALLOC) ||
                     (action_ff == bpa_pkg::ACT_REGION_ALLOC);
   assign used_sum = (bpa_pkg::COUNT_W + 1)'(used_total_ff) +
                     (bpa_pkg::COUNT_W + 1)'(delta_ff);

   always_comb begin
      if (count_up) begin
         used_next = (used_sum > (bpa_pkg::COUNT_W + 1)'(CAP)) ?
                     CAP : bpa_pkg::COUNT_W'(used_sum);
      end else begin
         used_next = (used_total_ff < delta_ff) ? '0 : used_total_ff - delta_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   logic rsp_free;
   logic [bpa_pkg::IDX_W+bpa_pkg::BLOCK_SHIFT-1:0] page_addr;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign page_addr = {word_ff, hit_pos, {bpa_pkg::BLOCK_SHIFT{1'b0}}};

   always_comb begin
      state_in      = state_ff;
      used_total_in = used_total_ff;
      action_in     = action_ff;
      start_in      = start_ff;
      last_in       = last_ff;
      word_in       = word_ff;
      delta_in      = delta_ff;
      status_in     = status_ff;
      baddr_in      = baddr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_item_in   = rsp_item_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               action_in = req_item.action;
               start_in  = acc_start;
               last_in   = acc_last;
               word_in   = acc_start[bpa_pkg::IDX_W-1:bpa_pkg::BIT_W];
               delta_in  = acc_delta;
               status_in = acc_status;
               baddr_in  = '0;
               state_in  = acc_touch ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if ((action_ff == bpa_pkg::ACT_ALLOC) && found) begin
               delta_in = bpa_pkg::COUNT_W'(1);
               baddr_in = bpa_pkg::BADDR_W'(page_addr);
            end
            if ((action_ff == bpa_pkg::ACT_ALLOC) && !found && last_word) begin
               status_in = bpa_pkg::STAT_NO_FREE;
            end
            if (scan_done) begin
               state_in = ST_FINISH;
            end else begin
               word_in = word_ff + bpa_pkg::WORD_W'(1);
            end
         end
         ST_FINISH: begin
            // Hold until the output register is free, then commit the count
            if (rsp_free) begin
               used_total_in             = used_next;
               rsp_valid_in              = 1'b1;
               rsp_item_in.block_address = baddr_ff;
               rsp_item_in.status        = status_ff;
               rsp_item_in.used_count    = used_next;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         block_count_ff <= bpa_pkg::COUNT_W'(bpa_pkg::COUNT_RESET);
         used_total_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         block_count_ff <= block_count_in;
         used_total_ff  <= used_total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      start_ff    <= start_in;
      last_ff     <= last_in;
      word_ff     <= word_in;
      delta_ff    <= delta_in;
      status_ff   <= status_in;
      baddr_ff    <= baddr_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   a_used_cap: assert property (@(posedge clock) disable iff (reset)
      used_total_ff <= CAP)
      else $error("used counter above its cap");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (word_ff <= last_ff[bpa_pkg::IDX_W-1:bpa_pkg::BIT_W]))
      else $error("scan ran past the last word");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish");

   a_finish_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && rsp_free |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("finish did not hand over the response");

endmodule

FILE: verif/tb_bitmap_page_allocator.sv
`timescale 1ns / 100ps

module tb_bitmap_page_allocator;

   localparam int PHASE_COUNT    = 10;
   localparam int PHASE_ITEMS    = 175;
   // Longest request walks 32 bitmap words plus the accept and finish overhead
   localparam int DRAIN_CYCLES   = 48;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int USED_CAP       = (bpa_pkg::NUM_BLOCKS > 2047) ? 2047 : bpa_pkg::NUM_BLOCKS;

   // Tracks the page bitmap and the used count, and matches every response
   // transaction against the oldest outstanding prediction.
   class alloc_tracker;
      logic [bpa_pkg::NUM_BLOCKS-1:0] free_bits;
      logic [bpa_pkg::COUNT_W-1:0]    block_count;
      int                             used;
      bpa_pkg::rsp_type               awaited_rsp[$];
      int                             errors;

      function new();
         free_bits   = '1;
         block_count = bpa_pkg::COUNT_W'(1024);
         used        = 0;
         errors      = 0;
      endfunction

      function int effective_count();
         return (int'(block_count) > bpa_pkg::NUM_BLOCKS) ?
                bpa_pkg::NUM_BLOCKS : int'(block_count);
      endfunction

      function void set_block_count(logic [bpa_pkg::CSR_DW-1:0] value);
         block_count = value[bpa_pkg::COUNT_W-1:0];
      endfunction

      function void bump_used(bit grow);
         if (grow && used < USED_CAP)
            used++;
         else if (!grow && used > 0)
            used--;
      endfunction

      function bpa_pkg::rsp_type run_action(bpa_pkg::req_type r);
         bpa_pkg::rsp_type   res;
         int                 limit;
         longint unsigned    first;
         longint unsigned    stop;
         bit                 releasing;
         limit             = effective_count();
         res.block_address = '0;
         res.status        = bpa_pkg::STAT_OK;
         case (r.action)
            bpa_pkg::ACT_ALLOC: begin
               res.status = bpa_pkg::STAT_NO_FREE;
               for (int i = 0; i < limit; i++) begin
                  if (free_bits[i]) begin
                     free_bits[i]      = 1'b0;
                     bump_used(1'b1);
                     res.block_address = bpa_pkg::BADDR_W'(longint'(i) *
                                                           bpa_pkg::BLOCK_BYTES);
                     res.status        = bpa_pkg::STAT_OK;
                     break;
                  end
               end
            end
            bpa_pkg::ACT_FREE: begin
               // Address zero is silently ignored
               if (r.address != '0) begin
                  first = r.address / bpa_pkg::BLOCK_BYTES;
                  if (first < limit) begin
                     free_bits[first] = 1'b1;
                     bump_used(1'b0);
                  end else begin
                     res.status = bpa_pkg::STAT_RANGE;
                  end
               end
            end
            default: begin
               releasing = (r.action == bpa_pkg::ACT_REGION_FREE);
               first     = r.address / bpa_pkg::BLOCK_BYTES;
               stop      = first + r.length / bpa_pkg::BLOCK_BYTES + 1;
               if (stop > limit) begin
                  stop       = limit;
                  res.status = bpa_pkg::STAT_RANGE;
               end
               // Count every touched page, whatever its previous state
               for (longint unsigned i = first; i < stop; i++) begin
                  free_bits[i] = releasing;
                  bump_used(!releasing);
               end
            end
         endcase
         res.used_count = bpa_pkg::COUNT_W'(used);
         return res;
      endfunction

      function void note_request(bpa_pkg::req_type r);
         awaited_rsp.push_back(run_action(r));
      endfunction

      task report(string what);
         $display("MISMATCH @%0t: %s", $realtime, what);
         errors++;
      endtask

      task check_response(bpa_pkg::rsp_type got);
         bpa_pkg::rsp_type want;
         if (awaited_rsp.size() == 0) begin
            report($sformatf("unexpected response %h", got));
            return;
         end
         want = awaited_rsp.pop_front();
         if (got.block_address !== want.block_address)
            report($sformatf("block_address %h, predicted %h",
                             got.block_address, want.block_address));
         if (got.status !== want.status)
            report($sformatf("status %0d, predicted %0d", got.status, want.status));
         if (got.used_count !== want.used_count)
            report($sformatf("used_count %0d, predicted %0d",
                             got.used_count, want.used_count));
      endtask

      function int pending();
         return awaited_rsp.size();
      endfunction
   endclass

   logic                         clock     = 1'b0;
   logic                         reset     = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   bpa_pkg::req_type             req_item  = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   bpa_pkg::rsp_type             rsp_item;
   logic                         psel      = 1'b0;
   logic                         penable   = 1'b0;
   logic                         pwrite    = 1'b0;
   logic [bpa_pkg::CSR_AW-1:0]   paddr     = '0;
   logic [bpa_pkg::CSR_DW-1:0]   pwdata    = '0;
   logic [bpa_pkg::CSR_DW-1:0]   prdata;
   logic                         pready;

   alloc_tracker        sb = new();
   int                  send_idle_pct  = 0;
   int                  recv_stall_pct = 0;
   int                  hold_request   = 0;
   int                  hold_left      = 0;
   int                  stuck_cycles   = 0;

   bitmap_page_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   // Offer one request transaction, with optional idle cycles in front, and
   // hold it until the block takes it. Valid is only lowered when idling.
   task send_request(bpa_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      do
         @(posedge clock);
      while (!req_ready);
      sb.note_request(item);
   endtask

   // Two-phase register write: setup, then access; the write lands on the
   // access edge since pready is tied high.
   task write_block_count(logic [bpa_pkg::CSR_DW-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= bpa_pkg::CSR_BLOCK_COUNT;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_block_count(value);
   endtask

   // Let every outstanding response arrive, then give the block time to settle.
   task drain();
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function bpa_pkg::req_type make_req(bpa_pkg::action_type act,
                                       logic [bpa_pkg::ADDR_W-1:0] addr,
                                       logic [bpa_pkg::LEN_W-1:0] len);
      bpa_pkg::req_type r;
      r.action  = act;
      r.address = addr;
      r.length  = len;
      return r;
   endfunction

   // Random request: mostly addresses around the managed range so that frees
   // and regions land on real pages, with a sprinkling of raw 32-bit values.
   function bpa_pkg::req_type random_req();
      bpa_pkg::req_type r;
      int               pick;
      int               page;
      pick = $urandom_range(99);
      if (pick < 38)
         r.action = bpa_pkg::ACT_ALLOC;
      else if (pick < 68)
         r.action = bpa_pkg::ACT_FREE;
      else if (pick < 84)
         r.action = bpa_pkg::ACT_REGION_ALLOC;
      else
         r.action = bpa_pkg::ACT_REGION_FREE;

      pick = $urandom_range(9);
      if (pick == 0) begin
         r.address = $urandom;
      end else if (pick == 1) begin
         r.address = '0;
      end else begin
         page      = $urandom_range(sb.effective_count() + 3);
         r.address = bpa_pkg::ADDR_W'(page * bpa_pkg::BLOCK_BYTES);
         if ($urandom_range(3) == 0)
            r.address += $urandom_range(bpa_pkg::BLOCK_BYTES - 1);
      end

      pick = $urandom_range(9);
      if (pick < 6)
         r.length = bpa_pkg::LEN_W'($urandom_range(3) * bpa_pkg::BLOCK_BYTES +
                                    $urandom_range(1) *
                                    $urandom_range(bpa_pkg::BLOCK_BYTES - 1));
      else if (pick < 8)
         r.length = bpa_pkg::LEN_W'($urandom_range(64) * bpa_pkg::BLOCK_BYTES);
      else if (pick == 8)
         r.length = $urandom;
      else
         r.length = '1;
      return r;
   endfunction

   // Response side: check what is taken, then choose ready for the next edge.
   // A long hold-off, when asked for, is counted out here.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_item);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_request > 0) begin
            rsp_ready    <= 1'b0;
            hold_left     = hold_request - 1;
            hold_request  = 0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Abort when no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if (!reset && !((req_valid && req_ready) || (rsp_valid && rsp_ready))) begin
         stuck_cycles++;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("bitmap_page_allocator verification failed");
            $finish;
         end
      end else begin
         stuck_cycles = 0;
      end
   end

   initial begin
      logic [bpa_pkg::CSR_DW-1:0] count_plan [PHASE_COUNT];
      bpa_pkg::req_type           directed [$];

      count_plan = '{32'd1024, 32'd0, 32'd1, 32'd2047, 32'd33,
                     32'd32, 32'd700, 32'hFFFF_F840, 32'd1000, 32'd1024};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening at the reset block count of 1024.
      directed.push_back(make_req(bpa_pkg::ACT_ALLOC, '0, '0));        // page 0, reads 0
      directed.push_back(make_req(bpa_pkg::ACT_ALLOC, '0, '0));        // page 1
      directed.push_back(make_req(bpa_pkg::ACT_FREE, '0, '1));         // address zero ignored
      directed.push_back(make_req(bpa_pkg::ACT_FREE, 32'd4096 + 32'd123, '0)); // unaligned
      directed.push_back(make_req(bpa_pkg::ACT_FREE, 32'hFFFF_FFFF, '0));      // far out
      directed.push_back(make_req(bpa_pkg::ACT_FREE, 32'd1024 * 32'd4096, '0)); // past end
      directed.push_back(make_req(bpa_pkg::ACT_FREE, 32'd1023 * 32'd4096, '0)); // last page
      directed.push_back(make_req(bpa_pkg::ACT_REGION_ALLOC, 32'd8 * 32'd4096, '0));
      directed.push_back(make_req(bpa_pkg::ACT_REGION_ALLOC, 32'd1000 * 32'd4096,
                                  32'd100 * 32'd4096));                // clipped at the end
      directed.push_back(make_req(bpa_pkg::ACT_REGION_ALLOC, 32'hFFFF_F000, '1)); // past end
      directed.push_back(make_req(bpa_pkg::ACT_REGION_FREE, 32'hFFFF_FFFF, '0));  // past end
      directed.push_back(make_req(bpa_pkg::ACT_REGION_FREE, '0, '1));  // count floors at 0
      directed.push_back(make_req(bpa_pkg::ACT_REGION_ALLOC, '0, 32'd1023 * 32'd4096));
      directed.push_back(make_req(bpa_pkg::ACT_ALLOC, '0, '0));        // map full
      directed.push_back(make_req(bpa_pkg::ACT_REGION_ALLOC, '0, '0)); // count capped
      directed.push_back(make_req(bpa_pkg::ACT_REGION_FREE, 32'd5 * 32'd4096 + 32'd7,
                                  32'd2 * 32'd4096 + 32'd5));          // pages 5..7
      directed.push_back(make_req(bpa_pkg::ACT_ALLOC, '0, '0));        // first fit picks 5
      directed.push_back(make_req(bpa_pkg::ACT_FREE, 32'd6 * 32'd4096, '0));
      directed.push_back(make_req(bpa_pkg::ACT_ALLOC, '0, '0));
      directed.push_back(make_req(bpa_pkg::ACT_REGION_FREE, 32'd31 * 32'd4096,
                                  32'd1 * 32'd4096));                  // spans a word boundary
      directed.push_back(make_req(bpa_pkg::ACT_ALLOC, '0, '0));
      foreach (directed[i])
         send_request(directed[i]);

      // Random phases: each one moves the block count and the idling pattern.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         req_valid <= 1'b0;
         drain();
         write_block_count(count_plan[phase]);
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         // Starve the response side for a while so the request side backs up
         if (phase == 4)
            hold_request = LONG_HOLD;
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_request(random_req());
      end

      req_valid <= 1'b0;
      drain();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("bitmap_page_allocator verification clean");
      else
         $display("bitmap_page_allocator verification failed");
      $finish;
   end

endmodule

FILE: bitmap_page_allocator.f
src/bpa_pkg.sv
src/bpa_map_store.sv
src/bitmap_page_allocator.sv
verif/tb_bitmap_page_allocator.sv
